/* rtl/core/matrix_sum_max_product_unit_macros.svh */
// Assertion helpers shared by the RTL of the matrix sum, maximum and product unit.
// Both macros check only while the synchronous active-low reset is released.
`ifndef MATRIX_SUM_MAX_PRODUCT_UNIT_MACROS_SVH
`define MATRIX_SUM_MAX_PRODUCT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression must never be true at a rising clock edge.
`define MSMP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define MSMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

`else

`define MSMP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define MSMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/msmp_pkg.sv */
// Shared types and constants of the matrix sum, maximum and product unit.
package msmp_pkg;

    // Fixed field widths.
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 3;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 2;
    localparam int TDATA_W = 40;

    // Default largest matrix size and the reset value of the size register.
    localparam int              MAX_DIM_DEF = 4;
    localparam logic [DIM_W-1:0] DIM_RESET  = 3'd4;

    // Result kinds carried on tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_SUM  = 2'd0,
        KIND_MAX  = 2'd1,
        KIND_PROD = 2'd2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the accepted element
        logic clr_ij;     // reset row and column counters
        logic next_ij;    // advance to the next row-major position
        logic sum_rd;     // read A and B at the current position
        logic sum_ld;     // load the sum element into the output register
        logic max_ld;     // load the maximum of A into the output register
        logic clr_k_acc;  // reset the inner index and the accumulator
        logic prd_rd;     // read A[i][k] and B[k][j]
        logic prd_mul;    // register the product of the read data
        logic prd_acc;    // add the product and step the inner index
        logic prd_ld;     // load the finished dot product into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_done;  // the element being stored completes B
        logic i_last;
        logic j_last;
        logic k_last;
        logic out_free;   // output register is empty
    } t_stat;

    // Clamp a written size to the supported range.
    function automatic int unsigned eff_dim(logic [DIM_W-1:0] d, int unsigned max_dim);
        int unsigned res;
        if (d == '0) begin
            res = 1;
        end else if (int'(d) > max_dim) begin
            res = max_dim;
        end else begin
            res = int'(d);
        end
        return res;
    endfunction

endpackage

/* rtl/core/msmp_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
module msmp_ram #(
    parameter int WIDTH = msmp_pkg::DATA_W,
    parameter int DEPTH = msmp_pkg::MAX_DIM_DEF * msmp_pkg::MAX_DIM_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/msmp_ctrl.sv */
// Sequencer: loads elements, then steps through the sum, the maximum and the product.
module msmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msmp_pkg::t_stat i_stat,
    output msmp_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_LOAD    = 9'b000000001,
        S_SUM_RD  = 9'b000000010,
        S_SUM_LD  = 9'b000000100,
        S_SUM_WT  = 9'b000001000,
        S_MAX_WT  = 9'b000010000,
        S_PRD_RD  = 9'b000100000,
        S_PRD_MUL = 9'b001000000,
        S_PRD_ACC = 9'b010000000,
        S_PRD_WT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.load_done) begin
                        o_cmd.clr_ij = 1'b1;
                        n_state      = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_SUM_LD;
            end
            S_SUM_LD: begin
                o_cmd.sum_ld = 1'b1;
                n_state      = S_SUM_WT;
            end
            S_SUM_WT: begin
                if (i_stat.out_free) begin
                    if (i_stat.i_last && i_stat.j_last) begin
                        o_cmd.max_ld = 1'b1;
                        o_cmd.clr_ij = 1'b1;
                        n_state      = S_MAX_WT;
                    end else begin
                        o_cmd.next_ij = 1'b1;
                        n_state       = S_SUM_RD;
                    end
                end
            end
            S_MAX_WT: begin
                if (i_stat.out_free) begin
                    o_cmd.clr_k_acc = 1'b1;
                    n_state         = S_PRD_RD;
                end
            end
            S_PRD_RD: begin
                o_cmd.prd_rd = 1'b1;
                n_state      = S_PRD_MUL;
            end
            S_PRD_MUL: begin
                o_cmd.prd_mul = 1'b1;
                n_state       = S_PRD_ACC;
            end
            S_PRD_ACC: begin
                if (i_stat.k_last) begin
                    o_cmd.prd_ld = 1'b1;
                    n_state      = S_PRD_WT;
                end else begin
                    o_cmd.prd_acc = 1'b1;
                    n_state       = S_PRD_RD;
                end
            end
            S_PRD_WT: begin
                if (i_stat.out_free) begin
                    if (i_stat.i_last && i_stat.j_last) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.next_ij   = 1'b1;
                        o_cmd.clr_k_acc = 1'b1;
                        n_state         = S_PRD_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/msmp_dp.sv */
`include "matrix_sum_max_product_unit_macros.svh"

// Datapath: matrix stores, load counter, running maximum, index counters,
// multiply-accumulate and the output register.
module msmp_dp #(
    parameter int MAX_DIM = msmp_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msmp_pkg::t_cmd                     i_cmd,
    output msmp_pkg::t_stat                    o_stat,
    input  logic [msmp_pkg::DATA_W-1:0]        i_element,
    input  logic                              i_cfg_valid,
    input  logic [msmp_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output msmp_pkg::t_kind                    o_out_kind,
    output logic [msmp_pkg::IDX_W-1:0]         o_out_row,
    output logic [msmp_pkg::IDX_W-1:0]         o_out_col,
    output logic [msmp_pkg::DATA_W-1:0]        o_out_value,
    output logic                              o_out_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int NNW   = $clog2(DEPTH + 1);
    localparam int PW    = 2 * NW;

    // Size and load state.
    logic [NW-1:0]  r_dim;
    logic [NNW-1:0] r_nn;
    logic [NNW-1:0] r_cnt;
    logic           r_in_b;
    logic [NW-1:0]  w_cfg_dim;
    logic [NW-1:0]  w_rst_dim;

    // Result walk state.
    logic [NW-1:0]  r_i;
    logic [NW-1:0]  r_j;
    logic [NW-1:0]  r_k;
    logic [NW-1:0]  w_dim_m1;

    // Arithmetic.
    logic signed [msmp_pkg::DATA_W-1:0] r_max;
    logic [msmp_pkg::DATA_W-1:0] r_prod;
    logic [msmp_pkg::DATA_W-1:0] r_acc;
    logic [msmp_pkg::DATA_W-1:0] w_mul;
    logic [msmp_pkg::DATA_W-1:0] w_dot;

    // Output register.
    logic                        r_out_valid;
    msmp_pkg::t_kind             r_out_kind;
    logic [msmp_pkg::IDX_W-1:0]  r_out_row;
    logic [msmp_pkg::IDX_W-1:0]  r_out_col;
    logic [msmp_pkg::DATA_W-1:0] r_out_value;
    logic                        r_out_last;

    // Store ports.
    logic                        w_we_a;
    logic                        w_we_b;
    logic                        w_re;
    logic [AW-1:0]               w_raddr_a;
    logic [AW-1:0]               w_raddr_b;
    logic [msmp_pkg::DATA_W-1:0] w_rdata_a;
    logic [msmp_pkg::DATA_W-1:0] w_rdata_b;
    logic [PW-1:0]               w_ij;
    logic [PW-1:0]               w_ik;
    logic [PW-1:0]               w_kj;

    assign w_cfg_dim = NW'(msmp_pkg::eff_dim(i_cfg_data, MAX_DIM));
    assign w_rst_dim = NW'(msmp_pkg::eff_dim(msmp_pkg::DIM_RESET, MAX_DIM));
    assign w_dim_m1  = r_dim - NW'(1);

    // Row-major addresses of the current position and of the dot-product operands.
    assign w_ij = PW'(r_i) * PW'(r_dim) + PW'(r_j);
    assign w_ik = PW'(r_i) * PW'(r_dim) + PW'(r_k);
    assign w_kj = PW'(r_k) * PW'(r_dim) + PW'(r_j);

    assign w_we_a    = i_cmd.load && !r_in_b;
    assign w_we_b    = i_cmd.load && r_in_b;
    assign w_re      = i_cmd.sum_rd || i_cmd.prd_rd;
    assign w_raddr_a = i_cmd.prd_rd ? w_ik[AW-1:0] : w_ij[AW-1:0];
    assign w_raddr_b = i_cmd.prd_rd ? w_kj[AW-1:0] : w_ij[AW-1:0];

    msmp_ram #(
        .WIDTH (msmp_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_element),
        .i_re    (w_re),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    msmp_ram #(
        .WIDTH (msmp_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_element),
        .i_re    (w_re),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // Status to the controller.
    assign o_stat.load_done = r_in_b && (r_cnt == r_nn - NNW'(1));
    assign o_stat.i_last    = (r_i == w_dim_m1);
    assign o_stat.j_last    = (r_j == w_dim_m1);
    assign o_stat.k_last    = (r_k == w_dim_m1);
    assign o_stat.out_free  = !r_out_valid;

    // Size register and load counter; a size write abandons a partial load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim  <= w_rst_dim;
            r_nn   <= NNW'(w_rst_dim) * NNW'(w_rst_dim);
            r_cnt  <= '0;
            r_in_b <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dim  <= w_cfg_dim;
            r_nn   <= NNW'(w_cfg_dim) * NNW'(w_cfg_dim);
            r_cnt  <= '0;
            r_in_b <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_cnt == r_nn - NNW'(1)) begin
                r_cnt  <= '0;
                r_in_b <= !r_in_b;
            end else begin
                r_cnt <= r_cnt + NNW'(1);
            end
        end
    end

    // Running maximum of A, taken as its elements arrive.
    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            if (r_cnt == '0 || $signed(i_element) > r_max) begin
                r_max <= $signed(i_element);
            end
        end
    end

    // Row, column and inner index counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            if (i_cmd.clr_ij) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.next_ij) begin
                if (r_j == w_dim_m1) begin
                    r_j <= '0;
                    r_i <= r_i + NW'(1);
                end else begin
                    r_j <= r_j + NW'(1);
                end
            end
            if (i_cmd.clr_k_acc) begin
                r_k <= '0;
            end else if (i_cmd.prd_acc) begin
                r_k <= r_k + NW'(1);
            end
        end
    end

    // Multiply-accumulate: the low 32 bits of each product are all that matter.
    assign w_mul = w_rdata_a * w_rdata_b;
    assign w_dot = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prd_mul) begin
            r_prod <= w_mul;
        end
        if (i_cmd.clr_k_acc) begin
            r_acc <= '0;
        end else if (i_cmd.prd_acc) begin
            r_acc <= w_dot;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sum_ld || i_cmd.max_ld || i_cmd.prd_ld) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.sum_ld) begin
            r_out_kind  <= msmp_pkg::KIND_SUM;
            r_out_row   <= msmp_pkg::IDX_W'(r_i);
            r_out_col   <= msmp_pkg::IDX_W'(r_j);
            r_out_value <= w_rdata_a + w_rdata_b;
            r_out_last  <= 1'b0;
        end else if (i_cmd.max_ld) begin
            r_out_kind  <= msmp_pkg::KIND_MAX;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= r_max;
            r_out_last  <= 1'b0;
        end else if (i_cmd.prd_ld) begin
            r_out_kind  <= msmp_pkg::KIND_PROD;
            r_out_row   <= msmp_pkg::IDX_W'(r_i);
            r_out_col   <= msmp_pkg::IDX_W'(r_j);
            r_out_value <= w_dot;
            r_out_last  <= o_stat.i_last && o_stat.j_last;
        end else begin
            r_out_kind <= r_out_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

    // A result is never loaded over one that has not been taken.
    `MSMP_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, (i_cmd.sum_ld || i_cmd.max_ld || i_cmd.prd_ld) && r_out_valid, "result loaded into a full output register")

    // The load counter stays inside the current matrix.
    `MSMP_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt >= r_nn, "load counter beyond matrix size")

    // The end-of-run mark only travels with a product element.
    `MSMP_ASSERT_IMPLY(a_last_kind, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_kind == msmp_pkg::KIND_PROD, "last flag on a non-product result")

    // Elements are stored only while no result is pending.
    `MSMP_ASSERT_IMPLY(a_load_idle, i_clk, i_rst_n, i_cmd.load, !r_out_valid, "element stored while results are pending")

endmodule

/* rtl/core/matrix_sum_max_product_unit.sv */
// Matrix sum, maximum and product unit. Elements of two square dim x dim signed
// 32-bit matrices arrive on the input stream, all of A and then all of B in
// row-major order, one transaction each; the size register (1 to MAX_DIM, 0 acts
// as 1, larger values as MAX_DIM) may be written only while the block is idle and
// restarts loading at A. Loading takes one cycle per element. The transaction that
// completes B starts the result phase, during which no input is taken: first the
// element-wise sum A+B row-major (tuser kind 0), then one item with the largest
// element of A (kind 1), then the product A*B row-major (kind 2) with tlast on its
// final element; all arithmetic wraps to 32 bits. Each matrix store has a single
// read port, and one shared multiplier serves every product term; its result is
// registered before it reaches the accumulator.
module matrix_sum_max_product_unit #(
    parameter int MAX_DIM = msmp_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input elements.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [msmp_pkg::DATA_W-1:0]         i_s_axis_tdata,  // [31:0] element
    // Results.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [msmp_pkg::TDATA_W-1:0]        o_m_axis_tdata,  // [1:0] row, [3:2] col,
                                                                 // [35:4] value, [39:36] zero
    output logic [msmp_pkg::KIND_W-1:0]         o_m_axis_tuser,  // [1:0] kind
    output logic                               o_m_axis_tlast,
    // Size register write.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [msmp_pkg::DIM_W-1:0]          i_cfg_data
);

    msmp_pkg::t_cmd              w_cmd;
    msmp_pkg::t_stat             w_stat;
    msmp_pkg::t_kind             w_kind;
    logic [msmp_pkg::IDX_W-1:0]  w_row;
    logic [msmp_pkg::IDX_W-1:0]  w_col;
    logic [msmp_pkg::DATA_W-1:0] w_value;

    msmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    msmp_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_element   (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (w_kind),
        .o_out_row   (w_row),
        .o_out_col   (w_col),
        .o_out_value (w_value),
        .o_out_last  (o_m_axis_tlast)
    );

    // Size writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Result packing.
    assign o_m_axis_tdata = {4'b0000, w_value, w_col, w_row};
    assign o_m_axis_tuser = w_kind;

endmodule
